/* design/fcqm_pkg.sv */
// fcqm_pkg: shared types and constants for the fax copy quality monitor.
// No dependencies; used by the interfaces, fcqm_page_cnt, the top level and the checker.
package fcqm_pkg;

  localparam int PCT_W      = 7;
  localparam int RUN_LIM_W  = 16;
  localparam int MARK_W     = 16;
  localparam int OUT_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int STEP_W     = 4;

  // register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] REG_MIN_PCT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_RUN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FINE    = 2'd2;

  // item kinds
  localparam logic KIND_ROW = 1'b0;
  localparam logic KIND_END = 1'b1;

  // 100 * good vs. min_pct * total: one shifted add or subtract per bit of each factor
  localparam logic [PCT_W-1:0]  PCT_SCALE = 7'd100;
  localparam logic [STEP_W-1:0] MUL_HALF  = 4'd7;
  localparam logic [STEP_W-1:0] MUL_LAST  = 4'd13;

  typedef enum logic [1:0] {
    CAUSE_NONE  = 2'd0,
    CAUSE_PCT   = 2'd1,
    CAUSE_RUN   = 2'd2,
    CAUSE_EMPTY = 2'd3
  } cause_t;

  typedef struct packed {
    logic strobe;   // row item accepted
    logic row_ok;
    logic clear;    // end item accepted: start a new page
  } row_cmd_t;

endpackage

/* design/fcqm_in_if.sv */
// fcqm_in_if: input channel (row and end-of-page words).
// Depends on fcqm_pkg.
interface fcqm_in_if;
  logic                       valid;
  logic                       ready;
  logic                       kind;
  logic                       row_ok;
  logic                       end_mark_seen;
  logic [fcqm_pkg::MARK_W-1:0] end_mark_row;

  modport source (output valid, kind, row_ok, end_mark_seen, end_mark_row, input ready);
  modport sink   (input valid, kind, row_ok, end_mark_seen, end_mark_row, output ready);
endinterface

/* design/fcqm_out_if.sv */
// fcqm_out_if: result channel (one word per page).
// Depends on fcqm_pkg.
interface fcqm_out_if;
  logic                       valid;
  logic                       ready;
  logic [fcqm_pkg::OUT_W-1:0] total_rows;
  logic [fcqm_pkg::OUT_W-1:0] bad_rows;
  logic [fcqm_pkg::OUT_W-1:0] longest_bad_run;
  logic                       accepted;
  logic [1:0]                 reject_cause;

  modport source (output valid, total_rows, bad_rows, longest_bad_run, accepted,
                  reject_cause, input ready);
  modport sink   (input valid, total_rows, bad_rows, longest_bad_run, accepted,
                  reject_cause, output ready);
endinterface

/* design/fcqm_cfg_if.sv */
// fcqm_cfg_if: configuration write channel.
// Depends on fcqm_pkg.
interface fcqm_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [fcqm_pkg::CFG_IDX_W-1:0]  index;
  logic [fcqm_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* design/fcqm_alu.sv */
// fcqm_alu: shared add/subtract unit stepped by the top-level sequencer.
// Depends on nothing.
module fcqm_alu #(
  parameter int W = 24
) (
  input  logic [W-1:0] acc,
  input  logic [W-1:0] opd,
  input  logic         sub,
  output logic [W-1:0] res
);
  assign res = sub ? (acc - opd) : (acc + opd);
endmodule

/* design/fcqm_page_cnt.sv */
// fcqm_page_cnt: per-page row counters, bad-run tracking, saturating.
// Depends on fcqm_pkg.
module fcqm_page_cnt #(
  parameter int COUNT_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  fcqm_pkg::row_cmd_t       cmd,
  output logic [COUNT_BITS-1:0]    row_total,
  output logic [COUNT_BITS-1:0]    bad_total,
  output logic [COUNT_BITS-1:0]    current_run,
  output logic [COUNT_BITS-1:0]    longest_run,
  output logic                     previous_bad
);
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  logic [COUNT_BITS-1:0] row_r, row_nxt, bad_r, bad_nxt;
  logic [COUNT_BITS-1:0] run_r, run_nxt, long_r, long_nxt;
  logic                  prev_r, prev_nxt;

  always_comb begin
    row_nxt  = row_r;
    bad_nxt  = bad_r;
    run_nxt  = run_r;
    long_nxt = long_r;
    prev_nxt = prev_r;
    if (cmd.clear) begin
      row_nxt  = '0;
      bad_nxt  = '0;
      run_nxt  = '0;
      long_nxt = '0;
      prev_nxt = 1'b0;
    end else if (cmd.strobe) begin
      if (row_r != CNT_MAX) row_nxt = row_r + 1'b1;
      if (cmd.row_ok) begin
        if (prev_r) begin
          if (run_r > long_r) long_nxt = run_r;
          run_nxt  = '0;
          prev_nxt = 1'b0;
        end
      end else begin
        if (bad_r != CNT_MAX) bad_nxt = bad_r + 1'b1;
        if (run_r != CNT_MAX) run_nxt = run_r + 1'b1;
        prev_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r  <= '0;
      bad_r  <= '0;
      run_r  <= '0;
      long_r <= '0;
      prev_r <= 1'b0;
    end else begin
      row_r  <= row_nxt;
      bad_r  <= bad_nxt;
      run_r  <= run_nxt;
      long_r <= long_nxt;
      prev_r <= prev_nxt;
    end
  end

  assign row_total    = row_r;
  assign bad_total    = bad_r;
  assign current_run  = run_r;
  assign longest_run  = long_r;
  assign previous_bad = prev_r;
endmodule

/* design/fax_copy_quality_monitor_core.sv */
// fax_copy_quality_monitor_core: top level of the fax copy quality monitor.
// Depends on fcqm_pkg, fcqm_in_if, fcqm_out_if, fcqm_cfg_if, fcqm_page_cnt, fcqm_alu.
//
//   channel  | dir | words                         | handshake
//   in_ch    | in  | row flag or end-of-page mark  | valid/ready
//   out_ch   | out | page counts and verdict       | valid/ready
//   cfg_ch   | in  | register index and data       | valid/ready (always ready)
//
// A row word is taken in ST_IDLE; the block stays ready.
// An end-of-page word goes through trim, 14 shift-add steps on the shared
// add/sub unit for the percentage compare, then the verdict into the output register.
// The next page may start while a result waits; a second verdict waits for out_ready.
// rst_n is synchronous, active low; it clears counters, config registers, out_valid and the sequencer.
module fax_copy_quality_monitor_core #(
  parameter int COUNT_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  fcqm_in_if.sink    in_ch,
  fcqm_out_if.source out_ch,
  fcqm_cfg_if.sink   cfg_ch
);
  localparam int TW = (COUNT_BITS > fcqm_pkg::MARK_W) ? COUNT_BITS : fcqm_pkg::MARK_W;
  localparam int AW = TW + fcqm_pkg::PCT_W + 1;
  localparam int LW = (COUNT_BITS > fcqm_pkg::RUN_LIM_W + 1) ? COUNT_BITS
                                                              : fcqm_pkg::RUN_LIM_W + 1;

  typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_JUDGE} state_t;

  state_t state_r;

  // config registers
  logic [fcqm_pkg::PCT_W-1:0]     min_pct_r;
  logic [fcqm_pkg::RUN_LIM_W-1:0] max_run_r;
  logic                           fine_r;

  // page counters
  fcqm_pkg::row_cmd_t    cmd;
  logic [COUNT_BITS-1:0] row_total, bad_total, current_run, longest_run;
  logic                  previous_bad;
  logic                  in_fire, end_fire;

  // captured end-of-page values
  logic [TW-1:0]         total_r, total_nxt, bad_r, bad_nxt;
  logic [COUNT_BITS-1:0] long_r;
  logic [AW-1:0]         acc_r;
  logic [fcqm_pkg::STEP_W-1:0] step_r;

  // output register
  logic                         out_valid_r;
  logic                         judge_go;
  logic [fcqm_pkg::OUT_W-1:0]   o_total_r, o_bad_r, o_long_r;
  fcqm_pkg::cause_t             o_cause_r;

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign in_fire  = in_ch.valid && in_ch.ready;
  assign end_fire = in_fire && (in_ch.kind == fcqm_pkg::KIND_END);

  assign cmd.strobe = in_fire && (in_ch.kind == fcqm_pkg::KIND_ROW);
  assign cmd.row_ok = in_ch.row_ok;
  assign cmd.clear  = end_fire;

  fcqm_page_cnt #(.COUNT_BITS(COUNT_BITS)) u_cnt (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .row_total    (row_total),
    .bad_total    (bad_total),
    .current_run  (current_run),
    .longest_run  (longest_run),
    .previous_bad (previous_bad)
  );

  // trimming at end of page
  logic [TW-1:0] row_x, bad_x, run_x, mark_x, drop;
  always_comb begin
    row_x  = TW'(row_total);
    bad_x  = TW'(bad_total);
    run_x  = TW'(current_run);
    mark_x = TW'(in_ch.end_mark_row);
    drop   = (row_x > mark_x) ? (row_x - mark_x) : '0;
    total_nxt = row_x;
    bad_nxt   = bad_x;
    if (in_ch.end_mark_seen) begin
      total_nxt = mark_x;
      bad_nxt   = (drop > bad_x) ? '0 : (bad_x - drop);
    end else if (previous_bad) begin
      total_nxt = (run_x > row_x) ? '0 : (row_x - run_x);
      bad_nxt   = (run_x > bad_x) ? '0 : (bad_x - run_x);
    end
  end

  // acc = min_pct * total - 100 * good, one shifted term per step
  logic [TW-1:0]               good;
  logic [fcqm_pkg::STEP_W-1:0] step_j;
  logic [2:0]                  sh;
  logic                        mul_sub, term_on;
  logic [AW-1:0]               opd, alu_res;

  assign good    = (bad_r > total_r) ? '0 : (total_r - bad_r);
  assign mul_sub = (step_r >= fcqm_pkg::MUL_HALF);
  assign step_j  = mul_sub ? (step_r - fcqm_pkg::MUL_HALF) : step_r;
  assign sh      = step_j[2:0];
  assign term_on = mul_sub ? fcqm_pkg::PCT_SCALE[sh] : min_pct_r[sh];
  assign opd     = term_on ? ((mul_sub ? AW'(good) : AW'(total_r)) << sh) : '0;

  fcqm_alu #(.W(AW)) u_alu (
    .acc (acc_r),
    .opd (opd),
    .sub (mul_sub),
    .res (alu_res)
  );

  // verdict
  logic [LW-1:0]    limit, long_x;
  logic             fail_pct, fail_run;
  fcqm_pkg::cause_t cause;
  always_comb begin
    limit    = fine_r ? (LW'(max_run_r) << 1) : LW'(max_run_r);
    long_x   = LW'(long_r);
    fail_pct = (min_pct_r != '0) && (total_r != '0) && !acc_r[AW-1] && (acc_r != '0);
    fail_run = (max_run_r != '0) && (long_x > limit);
    if (fail_pct)             cause = fcqm_pkg::CAUSE_PCT;
    else if (fail_run)        cause = fcqm_pkg::CAUSE_RUN;
    else if (total_r == '0)   cause = fcqm_pkg::CAUSE_EMPTY;
    else                      cause = fcqm_pkg::CAUSE_NONE;
  end

  // verdict loads when the output register is free or draining this cycle
  assign judge_go = (state_r == ST_JUDGE) && (!out_valid_r || out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      step_r      <= '0;
      min_pct_r   <= '0;
      max_run_r   <= '0;
      fine_r      <= 1'b0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          fcqm_pkg::REG_MIN_PCT: min_pct_r <= cfg_ch.data[fcqm_pkg::PCT_W-1:0];
          fcqm_pkg::REG_MAX_RUN: max_run_r <= cfg_ch.data[fcqm_pkg::RUN_LIM_W-1:0];
          fcqm_pkg::REG_FINE:    fine_r    <= cfg_ch.data[0];
          default: ;
        endcase
      end
      if (judge_go) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (end_fire) begin
            total_r <= total_nxt;
            bad_r   <= bad_nxt;
            long_r  <= longest_run;
            acc_r   <= '0;
            step_r  <= '0;
            state_r <= ST_MUL;
          end
        end
        ST_MUL: begin
          acc_r <= alu_res;
          if (step_r == fcqm_pkg::MUL_LAST) state_r <= ST_JUDGE;
          else step_r <= step_r + 1'b1;
        end
        ST_JUDGE: begin
          if (judge_go) begin
            o_total_r   <= total_r[fcqm_pkg::OUT_W-1:0];
            o_bad_r     <= bad_r[fcqm_pkg::OUT_W-1:0];
            o_long_r    <= long_x[fcqm_pkg::OUT_W-1:0];
            o_cause_r   <= cause;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.total_rows      = o_total_r;
  assign out_ch.bad_rows        = o_bad_r;
  assign out_ch.longest_bad_run = o_long_r;
  assign out_ch.accepted        = (o_cause_r == fcqm_pkg::CAUSE_NONE);
  assign out_ch.reject_cause    = o_cause_r;
endmodule

/* design/fcqm_checker.sv */
// fcqm_checker: port-level assertions for the quality monitor, bound to the top level.
// Depends on fcqm_pkg and fax_copy_quality_monitor_core.
module fcqm_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       in_kind,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [fcqm_pkg::OUT_W-1:0] out_total_rows,
  input logic                       out_accepted,
  input logic [1:0]                 out_reject_cause,
  input logic                       cfg_ready
);
  // a held result word keeps its verdict
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_reject_cause))
    else $error("result word changed while stalled");

  // end-of-page word starts the multi-cycle judge: not ready next cycle
  a_end_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_kind == fcqm_pkg::KIND_END) |=> !in_ready)
    else $error("ready right after end-of-page word");

  a_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_accepted == (out_reject_cause == fcqm_pkg::CAUSE_NONE)))
    else $error("accepted flag disagrees with reject cause");

  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_reject_cause == fcqm_pkg::CAUSE_EMPTY) |-> out_total_rows == '0)
    else $error("empty-page reject with nonzero row count");

  a_cfg_rdy: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
    else $error("config port not ready");
endmodule

bind fax_copy_quality_monitor_core fcqm_checker u_fcqm_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .in_kind          (in_ch.kind),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_total_rows   (out_ch.total_rows),
  .out_accepted     (out_ch.accepted),
  .out_reject_cause (out_ch.reject_cause),
  .cfg_ready        (cfg_ch.ready)
);

/* bench/tb_top.sv */
// tb_top: self-checking bench for fax_copy_quality_monitor_core; a page-verdict model
// scores every result word. Depends on fcqm_pkg, fcqm_in_if, fcqm_out_if, fcqm_cfg_if and the core.
module tb_top;

  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int TAIL        = 24;   // an end word needs trim, the shift-add steps and the output register

  typedef logic [fcqm_pkg::MARK_W-1:0]     mark_t;
  typedef logic [fcqm_pkg::CFG_DATA_W-1:0] cfg_data_t;

  typedef struct packed {
    logic  kind;
    logic  row_ok;
    logic  mark_seen;
    mark_t mark_row;
  } page_word_t;

  typedef struct packed {
    logic [fcqm_pkg::OUT_W-1:0] total_rows;
    logic [fcqm_pkg::OUT_W-1:0] bad_rows;
    logic [fcqm_pkg::OUT_W-1:0] longest_bad_run;
    logic                       accepted;
    fcqm_pkg::cause_t           reject_cause;
  } verdict_t;

  // Tracks the page in progress and queues the verdict due for each end word.
  class page_verdicts;
    bit [fcqm_pkg::PCT_W-1:0]     min_pct;
    bit [fcqm_pkg::RUN_LIM_W-1:0] max_run;
    bit                           fine;
    bit [15:0]                    rows, bads, run, longest;
    bit                           prev_bad;
    verdict_t                     due[$];
    int                           errors;

    function void set_reg(logic [fcqm_pkg::CFG_IDX_W-1:0] idx, cfg_data_t data);
      case (idx)
        fcqm_pkg::REG_MIN_PCT: min_pct = data[fcqm_pkg::PCT_W-1:0];
        fcqm_pkg::REG_MAX_RUN: max_run = data[fcqm_pkg::RUN_LIM_W-1:0];
        fcqm_pkg::REG_FINE:    fine    = data[0];
        default: ;
      endcase
    endfunction

    function bit [15:0] sat_up(bit [15:0] v);
      return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    function int unsigned floor_sub(int unsigned a, int unsigned b);
      return (b > a) ? 0 : a - b;
    endfunction

    function void take_word(page_word_t w);
      int unsigned total, bad, pct, limit;
      verdict_t    v;
      if (w.kind == fcqm_pkg::KIND_ROW) begin
        rows = sat_up(rows);
        if (w.row_ok) begin
          if (prev_bad) begin
            if (run > longest) longest = run;
            run      = '0;
            prev_bad = 1'b0;
          end
        end else begin
          bads     = sat_up(bads);
          run      = sat_up(run);
          prev_bad = 1'b1;
        end
        return;
      end
      total = rows;
      bad   = bads;
      // the mark trims rows after it; otherwise a trailing bad run is dropped
      if (w.mark_seen) begin
        bad   = floor_sub(bad, floor_sub(total, w.mark_row));
        total = w.mark_row;
      end else if (prev_bad) begin
        total = floor_sub(total, run);
        bad   = floor_sub(bad, run);
      end
      v.reject_cause = fcqm_pkg::CAUSE_NONE;
      if (min_pct != 0 && total != 0) begin
        pct = (100 * floor_sub(total, bad)) / total;
        if (pct < min_pct) v.reject_cause = fcqm_pkg::CAUSE_PCT;
      end
      limit = fine ? 2 * max_run : max_run;
      if (v.reject_cause == fcqm_pkg::CAUSE_NONE && max_run != 0 && longest > limit)
        v.reject_cause = fcqm_pkg::CAUSE_RUN;
      if (v.reject_cause == fcqm_pkg::CAUSE_NONE && total == 0)
        v.reject_cause = fcqm_pkg::CAUSE_EMPTY;
      v.total_rows      = total[15:0];
      v.bad_rows        = bad[15:0];
      v.longest_bad_run = longest;
      v.accepted        = (v.reject_cause == fcqm_pkg::CAUSE_NONE);
      due.push_back(v);
      rows     = '0;
      bads     = '0;
      run      = '0;
      longest  = '0;
      prev_bad = 1'b0;
    endfunction

    function void match_verdict(verdict_t got);
      verdict_t want;
      if (due.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected verdict word: total %0d bad %0d run %0d acc %0d cause %0d",
                   got.total_rows, got.bad_rows, got.longest_bad_run, got.accepted,
                   got.reject_cause);
        return;
      end
      want = due.pop_front();
      if (got.total_rows !== want.total_rows || got.bad_rows !== want.bad_rows ||
          got.longest_bad_run !== want.longest_bad_run ||
          got.accepted !== want.accepted || got.reject_cause !== want.reject_cause) begin
        errors++;
        if (errors <= 10)
          $display("verdict mismatch: want total %0d bad %0d run %0d acc %0d cause %0d,",
                   want.total_rows, want.bad_rows, want.longest_bad_run, want.accepted,
                   want.reject_cause,
                   " got total %0d bad %0d run %0d acc %0d cause %0d",
                   got.total_rows, got.bad_rows, got.longest_bad_run,
                   got.accepted, got.reject_cause);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   cycles;
  int   sent;
  int   stall_left;
  bit   idle_on;
  bit   last_part;

  page_verdicts judge = new();

  fcqm_in_if  in_ch();
  fcqm_out_if out_ch();
  fcqm_cfg_if cfg_ch();

  fax_copy_quality_monitor_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // receiver stalls in bursts while idling is on
  always @(negedge clk) begin
    if (stall_left == 0 && idle_on && $urandom_range(0, 4) == 0)
      stall_left = $urandom_range(1, 7);
    if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left--;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : watch_verdicts
    verdict_t got;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got.total_rows      = out_ch.total_rows;
      got.bad_rows        = out_ch.bad_rows;
      got.longest_bad_run = out_ch.longest_bad_run;
      got.accepted        = out_ch.accepted;
      got.reject_cause    = fcqm_pkg::cause_t'(out_ch.reject_cause);
      judge.match_verdict(got);
    end
  end

  task automatic put_word(page_word_t w);
    @(negedge clk);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.kind          <= w.kind;
    in_ch.row_ok        <= w.row_ok;
    in_ch.end_mark_seen <= w.mark_seen;
    in_ch.end_mark_row  <= w.mark_row;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    judge.take_word(w);
    sent++;
  endtask

  // mark fields ride along on row words and must be ignored
  task automatic row(bit ok);
    page_word_t w;
    w.kind      = fcqm_pkg::KIND_ROW;
    w.row_ok    = ok;
    w.mark_seen = 1'($urandom_range(0, 1));
    w.mark_row  = mark_t'($urandom);
    put_word(w);
  endtask

  task automatic page_end(bit seen, mark_t mark);
    page_word_t w;
    w.kind      = fcqm_pkg::KIND_END;
    w.row_ok    = 1'($urandom_range(0, 1));
    w.mark_seen = seen;
    w.mark_row  = mark;
    put_word(w);
  endtask

  // drop valid and wait for every pending verdict, then let the block go quiet
  task automatic settle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (judge.due.size() != 0) @(posedge clk);
    repeat (TAIL) @(posedge clk);
  endtask

  task automatic cfg_write(logic [fcqm_pkg::CFG_IDX_W-1:0] idx, cfg_data_t data);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    judge.set_reg(idx, data);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // unused upper data bits are randomized; the block must mask them
  task automatic configure(int pct, int run_lim, bit f);
    cfg_data_t d;
    settle();
    d = cfg_data_t'($urandom);
    d[fcqm_pkg::PCT_W-1:0] = pct[fcqm_pkg::PCT_W-1:0];
    cfg_write(fcqm_pkg::REG_MIN_PCT, d);
    cfg_write(fcqm_pkg::REG_MAX_RUN, run_lim[fcqm_pkg::RUN_LIM_W-1:0]);
    d = cfg_data_t'($urandom);
    d[0] = f;
    cfg_write(fcqm_pkg::REG_FINE, d);
  endtask

  task automatic make_page();
    int    n, bad_pct, burst, d;
    mark_t mark;
    idle_on = !last_part && ($urandom_range(0, 4) != 0);
    n       = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 30);
    bad_pct = $urandom_range(0, 60);
    burst   = 0;
    repeat (n) begin
      if (burst > 0) begin
        burst--;
        row(1'b0);
      end else if ($urandom_range(0, 99) < bad_pct) begin
        burst = $urandom_range(0, 8);
        row(1'b0);
      end else begin
        row(1'b1);
      end
    end
    d = $urandom_range(1, 5);
    case ($urandom_range(0, 5))
      0: mark = mark_t'(n);
      1: mark = (n > d) ? mark_t'(n - d) : '0;
      2: mark = mark_t'(n + d);
      3: mark = mark_t'($urandom);
      4: mark = '0;
      default: mark = '1;
    endcase
    page_end(1'($urandom_range(0, 1)), mark);
  endtask

  task automatic run_pages(int words);
    int target;
    target = sent + words;
    while (sent < target) make_page();
  endtask

  initial begin
    rst_n               = 1'b0;
    idle_on             = 1'b0;
    last_part           = 1'b0;
    stall_left          = 0;
    in_ch.valid         = 1'b0;
    in_ch.kind          = fcqm_pkg::KIND_ROW;
    in_ch.row_ok        = 1'b0;
    in_ch.end_mark_seen = 1'b0;
    in_ch.end_mark_row  = '0;
    out_ch.ready        = 1'b0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.index        = fcqm_pkg::REG_MIN_PCT;
    cfg_ch.data         = '0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // directed pages
    configure(90, 3, 1'b0);
    idle_on = 1'b1;
    page_end(1'b0, mark_t'($urandom));             // empty page
    row(1'b1); row(1'b0); row(1'b0); row(1'b1);
    page_end(1'b0, mark_t'($urandom));             // half good
    row(1'b0); row(1'b1);
    page_end(1'b1, 16'hFFFF);                      // mark past the row count
    row(1'b1); row(1'b0); row(1'b0);
    page_end(1'b0, 16'd0);                         // trailing bad run trimmed
    row(1'b1); repeat (4) row(1'b0);
    page_end(1'b1, 16'd2);                         // mark cuts into trailing run
    repeat (4) row(1'b0); row(1'b1);
    page_end(1'b1, 16'd1);                         // good percent, run too long

    // random pages across several settings
    configure(0, 0, 1'b0);
    run_pages(130);
    configure(100, 65535, 1'b1);
    run_pages(130);
    configure(127, 1, 1'b0);
    run_pages(60);
    settle();
    run_pages(60);
    configure($urandom_range(40, 100), $urandom_range(1, 6), 1'($urandom_range(0, 1)));
    run_pages(140);
    configure($urandom_range(0, 127), $urandom_range(0, 10), 1'($urandom_range(0, 1)));
    run_pages(140);

    last_part = 1'b1;
    configure($urandom_range(60, 100), $urandom_range(1, 4), 1'b1);
    run_pages(130);
    settle();

    if (judge.errors == 0 && judge.due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
